FILE: hw/rtl/nrs_pkg.sv
// ----------------------------------------------------------------------------
// nrs_pkg
// Shared types and constants for the nonce replay store: store geometry,
// verdict codes and the request and result payloads.
// ----------------------------------------------------------------------------
package nrs_pkg;

  localparam int ENTRIES = 32;
  localparam int IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int CNT_W   = $clog2(ENTRIES + 1);
  localparam int KEY_W   = 64;
  localparam int TIME_W  = 40;
  localparam int CTR_W   = 32;
  localparam int LIVE_W  = 6;

  typedef enum logic [1:0] {
    VERDICT_OK        = 2'd0,
    VERDICT_MALFORMED = 2'd1,
    VERDICT_REPLAYED  = 2'd2,
    VERDICT_FULL      = 2'd3
  } verdict_t;

  typedef struct packed {
    logic [KEY_W-1:0]  nonce_high;
    logic [KEY_W-1:0]  nonce_low;
    logic              nonce_present;
    logic [TIME_W-1:0] expiry_time;
    logic [TIME_W-1:0] now_time;
  } req_t;

  typedef struct packed {
    verdict_t          verdict;
    logic [LIVE_W-1:0] live_entries;
    logic [CTR_W-1:0]  taken_total;
    logic [CTR_W-1:0]  replayed_total;
    logic [CTR_W-1:0]  full_total;
    logic [CTR_W-1:0]  expired_total;
  } rsp_t;

  // One stored entry: the full key and its expiry time.
  typedef struct packed {
    logic [KEY_W-1:0]  key_high;
    logic [KEY_W-1:0]  key_low;
    logic [TIME_W-1:0] expiry;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

endpackage

FILE: hw/rtl/nrs_ram.sv
// ----------------------------------------------------------------------------
// nrs_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module nrs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                     clk,
  input  logic                                     we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                         wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: hw/rtl/nonce_replay_store.sv
// ----------------------------------------------------------------------------
// nonce_replay_store
// Anti-replay store for one-time 128-bit nonces with expiry times.
//
//   Channel  Signals                       Direction  Payload
//   req      req_valid, req_ready, req     in         req_t
//   rsp      rsp_valid, rsp_ready, rsp     out        rsp_t
//
// A present nonce walks the single entry RAM read port once, reading and then
// checking each entry in turn, doing the expiry sweep, the key lookup and the
// free-slot search in the same pass. An absent nonce goes from idle
// straight to the finish state. req_ready is high only while idle.
// Reset clears the valid bits and counters at once; no clearing pass.
// A finished result waits in the rsp register; a stalled rsp holds the
// next result in the finish state until the register frees up.
// ----------------------------------------------------------------------------
module nonce_replay_store (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  output logic          req_ready,
  input  nrs_pkg::req_t req,
  output logic          rsp_valid,
  input  logic          rsp_ready,
  output nrs_pkg::rsp_t rsp
);

  import nrs_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_CHECK,
    ST_DECIDE,
    ST_FINISH
  } state_t;

  state_t            state;
  logic [ENTRIES-1:0] valid;
  logic [CNT_W-1:0]  count;
  logic [CTR_W-1:0]  taken_ctr;
  logic [CTR_W-1:0]  replayed_ctr;
  logic [CTR_W-1:0]  full_ctr;
  logic [CTR_W-1:0]  expired_ctr;

  logic [KEY_W-1:0]  key_high;
  logic [KEY_W-1:0]  key_low;
  logic [TIME_W-1:0] expiry;
  logic [TIME_W-1:0] now;
  logic [IDX_W-1:0]  idx;
  logic              hit;
  logic              free_found;
  logic [IDX_W-1:0]  free_idx;
  verdict_t          verdict;

  entry_t            rd_entry;
  entry_t            wr_entry;
  logic              ram_we;
  logic              slot_valid;
  logic              slot_expired;
  logic              slot_match;
  logic              can_insert;

  assign wr_entry = '{key_high: key_high, key_low: key_low, expiry: expiry};
  assign can_insert = !hit && (count < CNT_W'(ENTRIES)) && free_found;
  assign ram_we = (state == ST_DECIDE) && can_insert;

  nrs_ram #(
    .WIDTH(ENTRY_W),
    .DEPTH(ENTRIES)
  ) u_store (
    .clk  (clk),
    .we   (ram_we),
    .waddr(free_idx),
    .wdata(wr_entry),
    .raddr(idx),
    .rdata(rd_entry)
  );

  // Shared compare unit: one entry per visit.
  assign slot_valid   = valid[idx];
  assign slot_expired = slot_valid && (rd_entry.expiry <= now);
  assign slot_match   = slot_valid && !slot_expired &&
                        (rd_entry.key_high == key_high) &&
                        (rd_entry.key_low == key_low);

  assign req_ready = (state == ST_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      valid        <= '0;
      count        <= '0;
      taken_ctr    <= '0;
      replayed_ctr <= '0;
      full_ctr     <= '0;
      expired_ctr  <= '0;
      rsp_valid    <= 1'b0;
      idx          <= '0;
      hit          <= 1'b0;
      free_found   <= 1'b0;
    end else begin
      // The finish state loads the next result itself when the register frees.
      if (rsp_valid && rsp_ready && (state != ST_FINISH)) begin
        rsp_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (req_valid) begin
            key_high   <= req.nonce_high;
            key_low    <= req.nonce_low;
            expiry     <= req.expiry_time;
            now        <= req.now_time;
            idx        <= '0;
            hit        <= 1'b0;
            free_found <= 1'b0;
            if (req.nonce_present) begin
              state <= ST_READ;
            end else begin
              verdict <= VERDICT_MALFORMED;
              state   <= ST_FINISH;
            end
          end
        end
        ST_READ: begin
          state <= ST_CHECK;
        end
        ST_CHECK: begin
          if (slot_expired) begin
            valid[idx]  <= 1'b0;
            count       <= count - 1'b1;
            expired_ctr <= expired_ctr + 1'b1;
          end
          if (slot_match) begin
            hit <= 1'b1;
          end
          // The lowest slot that is free once the sweep has passed it.
          if (!free_found && (!slot_valid || slot_expired)) begin
            free_found <= 1'b1;
            free_idx   <= idx;
          end
          if (idx == IDX_W'(ENTRIES - 1)) begin
            state <= ST_DECIDE;
          end else begin
            idx   <= idx + 1'b1;
            state <= ST_READ;
          end
        end
        ST_DECIDE: begin
          if (hit) begin
            replayed_ctr <= replayed_ctr + 1'b1;
            verdict      <= VERDICT_REPLAYED;
          end else if (can_insert) begin
            valid[free_idx] <= 1'b1;
            count           <= count + 1'b1;
            taken_ctr       <= taken_ctr + 1'b1;
            verdict         <= VERDICT_OK;
          end else begin
            full_ctr <= full_ctr + 1'b1;
            verdict  <= VERDICT_FULL;
          end
          state <= ST_FINISH;
        end
        ST_FINISH: begin
          if (!rsp_valid || rsp_ready) begin
            rsp_valid          <= 1'b1;
            rsp.verdict        <= verdict;
            rsp.live_entries   <= LIVE_W'(count);
            rsp.taken_total    <= taken_ctr;
            rsp.replayed_total <= replayed_ctr;
            rsp.full_total     <= full_ctr;
            rsp.expired_total  <= expired_ctr;
            state              <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

`ifndef ASSERT_OFF
  // The live count always agrees with the valid bits.
  a_count_matches_valid: assert property (@(posedge clk) disable iff (rst)
    $countones(valid) == 32'(count))
    else $error("live count differs from number of valid entries");

  a_count_bounded: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(ENTRIES))
    else $error("live count exceeds store depth");

  // An accepted or replayed nonce always reports at least one live entry.
  a_ok_leaves_entry: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && (rsp.verdict == VERDICT_OK || rsp.verdict == VERDICT_REPLAYED))
      |-> (rsp.live_entries != '0))
    else $error("accepted or replayed nonce with an empty store");

  a_no_insert_on_hit: assert property (@(posedge clk) disable iff (rst)
    ram_we |-> (!hit && !valid[free_idx]))
    else $error("store write on a hit or into a live slot");
`endif

endmodule
